// ----- sv/aging_page_replacement_core_assert.svh -----
// Assertion macros used by the aging page replacement checker.
`ifndef AGING_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define AGING_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// Same-cycle implication, clocked on aclk and quiet while aresetn is low.
`define APRC_CHECK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk and quiet while aresetn is low.
`define APRC_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/aprc_pkg.sv -----
// Types and constants shared by the aging page replacement modules.
package aprc_pkg;

    // Fixed widths of the channel fields.
    localparam int PAGE_PORT_W  = 16;
    localparam int INDEX_PORT_W = 4;
    localparam int TOTAL_W      = 32;
    localparam int ACTIVE_W     = 5;

    // Frame count in use after reset.
    localparam logic [ACTIVE_W-1:0] ACTIVE_FRAMES_RESET = 5'd16;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_FILL = 4'b0100,
        ST_DONE = 4'b1000
    } aprc_state_t;

    // Per-frame verdict from the shared compare unit.
    typedef struct packed {
        logic match;  // valid frame holding the referenced page
        logic empty;  // frame not yet filled
        logic less;   // age below the running minimum, or first frame
    } frame_status_t;

endpackage

// ----- sv/aprc_frame_table.sv -----
// Frame table: valid flags, page tags and age counters with one read and one write port.
module aprc_frame_table #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16,
    parameter int AGE_BITS  = 8,
    parameter int IDX_W     = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [IDX_W-1:0]     rd_idx,
    output logic                 rd_valid,
    output logic [PAGE_BITS-1:0] rd_page,
    output logic [AGE_BITS-1:0]  rd_age,
    input  logic [IDX_W-1:0]     wr_idx,
    input  logic                 age_we,
    input  logic [AGE_BITS-1:0]  age_wdata,
    input  logic                 page_we,
    input  logic [PAGE_BITS-1:0] page_wdata
);
    import aprc_pkg::*;

    logic [FRAMES-1:0]    valid_reg;
    logic [PAGE_BITS-1:0] page_mem [FRAMES];
    logic [AGE_BITS-1:0]  age_mem [FRAMES];
    logic                 rd_valid_reg;
    logic [PAGE_BITS-1:0] rd_page_reg;
    logic [AGE_BITS-1:0]  rd_age_reg;

    // Valid flags clear on reset; a page write marks its frame filled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (page_we) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // Tag and age storage; contents of empty frames never decide a result.
    always_ff @(posedge aclk) begin
        if (page_we) begin
            page_mem[wr_idx] <= page_wdata;
        end
        if (age_we) begin
            age_mem[wr_idx] <= age_wdata;
        end
    end

    // Registered read of one frame per cycle.
    always_ff @(posedge aclk) begin
        rd_valid_reg <= valid_reg[rd_idx];
        rd_page_reg  <= page_mem[rd_idx];
        rd_age_reg   <= age_mem[rd_idx];
    end

    assign rd_valid = rd_valid_reg;
    assign rd_page  = rd_page_reg;
    assign rd_age   = rd_age_reg;

endmodule

// ----- sv/aprc_frame_unit.sv -----
// Shared compare and shift unit that judges one frame per cycle.
module aprc_frame_unit #(
    parameter int PAGE_BITS = 16,
    parameter int AGE_BITS  = 8
) (
    input  logic                   frame_valid,
    input  logic [PAGE_BITS-1:0]   frame_page,
    input  logic [AGE_BITS-1:0]    frame_age,
    input  logic [PAGE_BITS-1:0]   key_page,
    input  logic [AGE_BITS-1:0]    best_age,
    input  logic                   first_frame,
    input  logic                   set_top,
    output aprc_pkg::frame_status_t status,
    output logic [AGE_BITS-1:0]    age_next
);
    import aprc_pkg::*;

    localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};

    // Tag match, emptiness and running-minimum compare.
    always_comb begin
        status.match = frame_valid && (frame_page == key_page);
        status.empty = !frame_valid;
        status.less  = first_frame || (frame_age < best_age);
    end

    // Aging: shift right, and mark the first matching frame as just referenced.
    always_comb begin
        age_next = frame_age >> 1;
        if (status.match && set_top) begin
            age_next = age_next | AGE_TOP;
        end
    end

endmodule

// ----- sv/aging_page_replacement_core.sv -----
// Top level of the aging page replacement core: sequencer, counters and result register.
// One page reference is accepted when s_ready is high; the core then walks the active
// frames one per cycle through the frame table's single read port, matching tags,
// finding the first empty frame, tracking the oldest frame and writing back each
// shifted age, and finally places the page on a miss and updates the totals. A reference
// passes through the walk, the fill step and the done step before m_valid rises, and
// s_ready returns in the same cycle as m_valid, so a new reference is taken only once
// the last one's result is registered. A result still waiting in the output register
// holds the next reference at its last step until m_ready frees the register.
// The victim is the frame with the smallest age before this reference's shift, lowest
// index on ties. Frames above the active count keep their contents untouched. No
// clearing pass is needed after reset; cfg_data may be written at any time the core is
// idle and is always ready.
module aging_page_replacement_core #(
    parameter int FRAMES    = 16,
    parameter int AGE_BITS  = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Frame count register write.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [aprc_pkg::ACTIVE_W-1:0]       cfg_data,
    // Page reference in.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [aprc_pkg::PAGE_PORT_W-1:0]    s_page_number,
    // Result out.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic [aprc_pkg::INDEX_PORT_W-1:0]   m_frame_index,
    output logic                                m_evicted,
    output logic [aprc_pkg::PAGE_PORT_W-1:0]    m_evicted_page,
    output logic [aprc_pkg::TOTAL_W-1:0]        m_hit_total,
    output logic [aprc_pkg::TOTAL_W-1:0]        m_reference_total
);
    import aprc_pkg::*;

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};
    localparam logic [IDX_W-1:0] LAST_FRAME = IDX_W'(FRAMES - 1);

    aprc_state_t          state_reg, state_next;
    logic [ACTIVE_W-1:0]  active_frames_reg;
    logic [PAGE_BITS-1:0] key_page_reg, key_page_next;
    logic [IDX_W-1:0]     last_idx_reg, last_idx_next;
    logic [IDX_W-1:0]     eval_idx_reg, eval_idx_next;
    logic                 hit_found_reg, hit_found_next;
    logic                 empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]     hit_slot_reg, hit_slot_next;
    logic [IDX_W-1:0]     empty_slot_reg, empty_slot_next;
    logic [IDX_W-1:0]     vict_slot_reg, vict_slot_next;
    logic [PAGE_BITS-1:0] vict_page_reg, vict_page_next;
    logic [AGE_BITS-1:0]  best_age_reg, best_age_next;
    logic [TOTAL_W-1:0]   hit_count_reg, hit_count_next;
    logic [TOTAL_W-1:0]   ref_count_reg, ref_count_next;

    logic                    m_valid_reg, m_valid_next;
    logic                    m_hit_reg, m_hit_next;
    logic [INDEX_PORT_W-1:0] m_frame_index_reg, m_frame_index_next;
    logic                    m_evicted_reg, m_evicted_next;
    logic [PAGE_PORT_W-1:0]  m_evicted_page_reg, m_evicted_page_next;
    logic [TOTAL_W-1:0]      m_hit_total_reg, m_hit_total_next;
    logic [TOTAL_W-1:0]      m_ref_total_reg, m_ref_total_next;

    logic [IDX_W-1:0]     rd_idx;
    logic                 rd_valid;
    logic [PAGE_BITS-1:0] rd_page;
    logic [AGE_BITS-1:0]  rd_age;
    logic [IDX_W-1:0]     wr_idx;
    logic                 age_we;
    logic [AGE_BITS-1:0]  age_wdata;
    logic                 page_we;
    frame_status_t        status;
    logic [AGE_BITS-1:0]  age_next;
    logic [IDX_W-1:0]     final_slot;
    logic                 final_evicted;
    logic                 out_free;
    logic                 s_accept;

    // Frame storage.
    aprc_frame_table #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .AGE_BITS  (AGE_BITS),
        .IDX_W     (IDX_W)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_idx     (rd_idx),
        .rd_valid   (rd_valid),
        .rd_page    (rd_page),
        .rd_age     (rd_age),
        .wr_idx     (wr_idx),
        .age_we     (age_we),
        .age_wdata  (age_wdata),
        .page_we    (page_we),
        .page_wdata (key_page_reg)
    );

    // Compare and shift unit shared by every frame of the walk.
    aprc_frame_unit #(
        .PAGE_BITS (PAGE_BITS),
        .AGE_BITS  (AGE_BITS)
    ) u_unit (
        .frame_valid (rd_valid),
        .frame_page  (rd_page),
        .frame_age   (rd_age),
        .key_page    (key_page_reg),
        .best_age    (best_age_reg),
        .first_frame (eval_idx_reg == '0),
        .set_top     (!hit_found_reg),
        .status      (status),
        .age_next    (age_next)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // Read address: frame 0 while idle, the following frame during the walk.
    always_comb begin
        rd_idx = '0;
        if (state_reg == ST_SCAN && eval_idx_reg != LAST_FRAME) begin
            rd_idx = eval_idx_reg + 1'b1;
        end
    end

    // Placement decision once the walk is over.
    always_comb begin
        final_evicted = !hit_found_reg && !empty_found_reg;
        priority if (hit_found_reg) begin
            final_slot = hit_slot_reg;
        end else if (empty_found_reg) begin
            final_slot = empty_slot_reg;
        end else begin
            final_slot = vict_slot_reg;
        end
    end

    // Frame count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_frames_reg <= ACTIVE_FRAMES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            active_frames_reg <= cfg_data;
        end
    end

    // Sequencer.
    always_comb begin
        int n_frames;
        n_frames         = 1;
        state_next       = state_reg;
        key_page_next    = key_page_reg;
        last_idx_next    = last_idx_reg;
        eval_idx_next    = eval_idx_reg;
        hit_found_next   = hit_found_reg;
        empty_found_next = empty_found_reg;
        hit_slot_next    = hit_slot_reg;
        empty_slot_next  = empty_slot_reg;
        vict_slot_next   = vict_slot_reg;
        vict_page_next   = vict_page_reg;
        best_age_next    = best_age_reg;
        hit_count_next   = hit_count_reg;
        ref_count_next   = ref_count_reg;
        wr_idx           = eval_idx_reg;
        age_we           = 1'b0;
        age_wdata        = age_next;
        page_we          = 1'b0;

        m_valid_next        = m_valid_reg && !m_ready;
        m_hit_next          = m_hit_reg;
        m_frame_index_next  = m_frame_index_reg;
        m_evicted_next      = m_evicted_reg;
        m_evicted_page_next = m_evicted_page_reg;
        m_hit_total_next    = m_hit_total_reg;
        m_ref_total_next    = m_ref_total_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    // Clamp the frame count to the range one to FRAMES.
                    if (active_frames_reg == '0) begin
                        n_frames = 1;
                    end else if (int'(active_frames_reg) > FRAMES) begin
                        n_frames = FRAMES;
                    end else begin
                        n_frames = int'(active_frames_reg);
                    end
                    key_page_next    = PAGE_BITS'(s_page_number);
                    last_idx_next    = IDX_W'(n_frames - 1);
                    eval_idx_next    = '0;
                    hit_found_next   = 1'b0;
                    empty_found_next = 1'b0;
                    state_next       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // First matching frame is the hit.
                if (status.match && !hit_found_reg) begin
                    hit_found_next = 1'b1;
                    hit_slot_next  = eval_idx_reg;
                end
                // Lowest empty frame.
                if (status.empty && !empty_found_reg) begin
                    empty_found_next = 1'b1;
                    empty_slot_next  = eval_idx_reg;
                end
                // Oldest frame by pre-shift age, lowest index on ties.
                if (status.less) begin
                    best_age_next  = rd_age;
                    vict_slot_next = eval_idx_reg;
                    vict_page_next = rd_page;
                end
                // Write back the shifted age of every filled frame.
                age_we = rd_valid;
                if (eval_idx_reg == last_idx_reg) begin
                    state_next = ST_FILL;
                end else begin
                    eval_idx_next = eval_idx_reg + 1'b1;
                end
            end
            ST_FILL: begin
                // On a miss the page takes its frame with a fresh age.
                wr_idx    = final_slot;
                age_wdata = AGE_TOP;
                age_we    = !hit_found_reg;
                page_we   = !hit_found_reg;
                if (hit_found_reg && hit_count_reg != '1) begin
                    hit_count_next = hit_count_reg + 1'b1;
                end
                if (ref_count_reg != '1) begin
                    ref_count_next = ref_count_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_hit_next          = hit_found_reg;
                    m_frame_index_next  = INDEX_PORT_W'(final_slot);
                    m_evicted_next      = final_evicted;
                    m_evicted_page_next = final_evicted ? PAGE_PORT_W'(vict_page_reg) : '0;
                    m_hit_total_next    = hit_count_reg;
                    m_ref_total_next    = ref_count_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hit_count_reg <= '0;
            ref_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hit_count_reg <= hit_count_next;
            ref_count_reg <= ref_count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Walk and result payload registers.
    always_ff @(posedge aclk) begin
        key_page_reg       <= key_page_next;
        last_idx_reg       <= last_idx_next;
        eval_idx_reg       <= eval_idx_next;
        hit_found_reg      <= hit_found_next;
        empty_found_reg    <= empty_found_next;
        hit_slot_reg       <= hit_slot_next;
        empty_slot_reg     <= empty_slot_next;
        vict_slot_reg      <= vict_slot_next;
        vict_page_reg      <= vict_page_next;
        best_age_reg       <= best_age_next;
        m_hit_reg          <= m_hit_next;
        m_frame_index_reg  <= m_frame_index_next;
        m_evicted_reg      <= m_evicted_next;
        m_evicted_page_reg <= m_evicted_page_next;
        m_hit_total_reg    <= m_hit_total_next;
        m_ref_total_reg    <= m_ref_total_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_hit             = m_hit_reg;
    assign m_frame_index     = m_frame_index_reg;
    assign m_evicted         = m_evicted_reg;
    assign m_evicted_page    = m_evicted_page_reg;
    assign m_hit_total       = m_hit_total_reg;
    assign m_reference_total = m_ref_total_reg;

endmodule

// ----- sv/aging_page_replacement_core_checker.sv -----
// Port-level checker for the aging page replacement core, with its bind.
`include "aging_page_replacement_core_assert.svh"

module aging_page_replacement_core_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_hit,
    input logic [aprc_pkg::INDEX_PORT_W-1:0]   m_frame_index,
    input logic                                m_evicted,
    input logic [aprc_pkg::PAGE_PORT_W-1:0]    m_evicted_page,
    input logic [aprc_pkg::TOTAL_W-1:0]        m_hit_total,
    input logic [aprc_pkg::TOTAL_W-1:0]        m_reference_total
);
    import aprc_pkg::*;

    // A stalled result beat holds its payload.
    `APRC_CHECK_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_hit) && $stable(m_frame_index) && $stable(m_evicted_page) && $stable(m_reference_total), "result changed while stalled")

    // A reference keeps the core busy for at least the following cycle.
    `APRC_CHECK_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "core ready right after accepting a reference")

    // Hits can never outnumber references.
    `APRC_CHECK_SAME(a_totals_order, m_valid, m_hit_total <= m_reference_total, "hit total above reference total")

    // A hit never evicts, and no eviction shows no page.
    `APRC_CHECK_SAME(a_hit_no_evict, m_valid && (m_hit || !m_evicted), !(m_hit && m_evicted) && m_evicted_page == '0, "eviction reported with a hit or stray evicted page")

endmodule

bind aging_page_replacement_core aging_page_replacement_core_checker u_checker (.*);
